### rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants of the maximal square scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int SYM_W     = 8;
    localparam int SIZE_W    = 11;
    localparam int ROW_W     = 16;
    localparam int BCOL_W    = 10;
    localparam int GCOLS_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_SYM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_SYM = 2'd3;

    localparam logic [GCOLS_W-1:0] GRID_COLS_RST   = 11'd1;
    localparam logic [ROW_W-1:0]   GRID_ROWS_RST   = 16'd1;
    localparam logic [SYM_W-1:0]   EMPTY_SYM_RST    = 8'd46;
    localparam logic [SYM_W-1:0]   OBSTACLE_SYM_RST = 8'd111;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             grid_start;
    } in_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] cell_size;
        logic [SIZE_W-1:0] best_size;
        logic [ROW_W-1:0]  best_row;
        logic [BCOL_W-1:0] best_col;
        logic              bad_symbol;
        logic              grid_done;
    } out_item_t;

    typedef struct packed {
        logic [GCOLS_W-1:0] grid_cols;
        logic [ROW_W-1:0]   grid_rows;
        logic [SYM_W-1:0]   empty_symbol;
        logic [SYM_W-1:0]   obstacle_symbol;
    } cfg_t;

    // per-item control carried from the front end to the compute stage
    typedef struct packed {
        logic is_empty;
        logic is_bad;
        logic start;
        logic last_col;
        logic last_row;
        logic col_zero;
        logic row_zero;
        logic fwd_hit;
    } ctl_t;

endpackage

### rtl/max_square_scan.sv
// ----------------------------------------------------------------------------
// max_square_scan
// Largest all-empty square over a grid streamed in raster order.
// ----------------------------------------------------------------------------
// One grid cell per item, one item per clock cycle sustained while out_stall is
// low. The item and its row store read are registered at accept, then the compute
// stage fills the output register once that register is free or not stalled.
// The sizes of the row above live in a single-port-write, single-port-read row
// store of MAX_COLS entries. Its read for a cell is issued at accept. A cell that
// reads the entry being written by the cell just ahead of it takes the value from
// the output register. The row store needs no clearing, because the value read
// for row 0 is never used. The rate is set by that one read and one write per cell.
module max_square_scan #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mss_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mss_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mss_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EW = (CW + 1 > mss_pkg::GCOLS_W) ? CW + 1 : mss_pkg::GCOLS_W;

    mss_pkg::cfg_t               cfg_reg;
    mss_pkg::cfg_t               cfg_next;

    logic                        s1_fire;
    logic                        s1_valid;
    logic [CW-1:0]               s1_col;
    logic [mss_pkg::ROW_W-1:0]   s1_row;
    mss_pkg::ctl_t               s1_ctl;
    logic                        rd_en;
    logic [CW-1:0]               rd_addr;
    logic [mss_pkg::SIZE_W-1:0]  rd_data;
    logic                        wr_en;
    logic [CW-1:0]               wr_addr;
    logic [mss_pkg::SIZE_W-1:0]  wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mss_pkg::REG_GRID_COLS:
                    cfg_next.grid_cols = cfg_data[mss_pkg::GCOLS_W-1:0];
                mss_pkg::REG_GRID_ROWS:
                    cfg_next.grid_rows = cfg_data[mss_pkg::ROW_W-1:0];
                mss_pkg::REG_EMPTY_SYM:
                    cfg_next.empty_symbol = cfg_data[mss_pkg::SYM_W-1:0];
                mss_pkg::REG_OBSTACLE_SYM:
                    cfg_next.obstacle_symbol = cfg_data[mss_pkg::SYM_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_cols       <= mss_pkg::GRID_COLS_RST;
            cfg_reg.grid_rows       <= mss_pkg::GRID_ROWS_RST;
            cfg_reg.empty_symbol    <= mss_pkg::EMPTY_SYM_RST;
            cfg_reg.obstacle_symbol <= mss_pkg::OBSTACLE_SYM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mss_front #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW),
        .EW       (EW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .s1_fire  (s1_fire),
        .s1_valid (s1_valid),
        .s1_col   (s1_col),
        .s1_row   (s1_row),
        .s1_ctl   (s1_ctl),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    mss_row_mem #(
        .DEPTH  (MAX_COLS),
        .WIDTH  (mss_pkg::SIZE_W),
        .ADDR_W (CW)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mss_core #(
        .CW (CW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_col    (s1_col),
        .s1_row    (s1_row),
        .s1_ctl    (s1_ctl),
        .rd_data   (rd_data),
        .s1_fire   (s1_fire),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

### rtl/mss_row_mem.sv
// ----------------------------------------------------------------------------
// mss_row_mem
// Row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mss_row_mem #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 11,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/mss_front.sv
// ----------------------------------------------------------------------------
// mss_front
// Input side: classifies the symbol, tracks row and column, issues the row
// store read and holds the item for the compute stage.
// ----------------------------------------------------------------------------
module mss_front #(
    parameter int MAX_COLS = 1024,
    parameter int CW       = 10,
    parameter int EW       = 11
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mss_pkg::in_item_t      in_item,
    input  mss_pkg::cfg_t          cfg,
    input  logic                   s1_fire,
    output logic                   s1_valid,
    output logic [CW-1:0]          s1_col,
    output logic [mss_pkg::ROW_W-1:0] s1_row,
    output mss_pkg::ctl_t          s1_ctl,
    output logic                   rd_en,
    output logic [CW-1:0]          rd_addr
);

    localparam int RW = mss_pkg::ROW_W;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    mss_pkg::ctl_t     s1_ctl_reg;
    logic [CW-1:0]     col_cnt_reg;
    logic [CW-1:0]     col_cnt_next;
    logic [RW-1:0]     row_cnt_reg;
    logic [RW-1:0]     row_cnt_next;

    logic              accept;
    logic [CW-1:0]     col_cur;
    logic [RW-1:0]     row_cur;
    logic [EW-1:0]     cols_eff;
    logic [RW:0]       rows_eff;
    logic [EW-1:0]     col_plus;
    logic [RW:0]       row_plus;
    mss_pkg::ctl_t     ctl;

    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    // zero counts act as one, too many columns clamp to the store depth
    always_comb
    begin
        if (cfg.grid_cols == '0)
        begin
            cols_eff = EW'(1);
        end
        else if (EW'(cfg.grid_cols) > EW'(MAX_COLS))
        begin
            cols_eff = EW'(MAX_COLS);
        end
        else
        begin
            cols_eff = EW'(cfg.grid_cols);
        end
        rows_eff = (cfg.grid_rows == '0) ? (RW+1)'(1) : {1'b0, cfg.grid_rows};
    end

    assign col_cur  = in_item.grid_start ? '0 : col_cnt_reg;
    assign row_cur  = in_item.grid_start ? '0 : row_cnt_reg;
    assign col_plus = EW'(col_cur) + EW'(1);
    assign row_plus = {1'b0, row_cur} + (RW+1)'(1);

    always_comb
    begin
        ctl.is_empty = 1'b0;
        ctl.is_bad   = 1'b0;
        if (in_item.symbol == cfg.obstacle_symbol)
        begin
            ctl.is_empty = 1'b0;
        end
        else if (in_item.symbol == cfg.empty_symbol)
        begin
            ctl.is_empty = 1'b1;
        end
        else
        begin
            ctl.is_bad = 1'b1;
        end
        ctl.start    = in_item.grid_start;
        ctl.last_col = col_plus >= cols_eff;
        ctl.last_row = row_plus >= rows_eff;
        ctl.col_zero = col_cur == '0;
        ctl.row_zero = row_cur == '0;
        // the item leaving the compute stage writes this entry at the same edge
        ctl.fwd_hit  = s1_fire && (s1_col_reg == col_cur);
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (ctl.last_col && ctl.last_row)
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
            end
            else if (ctl.last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_cur + RW'(1);
            end
            else
            begin
                col_cnt_next = col_cur + CW'(1);
                row_cnt_next = row_cur;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_cur;
            s1_row_reg <= row_cur;
            s1_ctl_reg <= ctl;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign rd_en    = accept;
    assign rd_addr  = col_cur;

endmodule

### rtl/mss_core.sv
// ----------------------------------------------------------------------------
// mss_core
// Compute stage: square size from left, top and diagonal neighbours, best
// square tracking, row store write-back and the output register.
// ----------------------------------------------------------------------------
module mss_core #(
    parameter int CW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s1_valid,
    input  logic [CW-1:0]               s1_col,
    input  logic [mss_pkg::ROW_W-1:0]   s1_row,
    input  mss_pkg::ctl_t               s1_ctl,
    input  logic [mss_pkg::SIZE_W-1:0]  rd_data,
    output logic                        s1_fire,
    output logic                        wr_en,
    output logic [CW-1:0]               wr_addr,
    output logic [mss_pkg::SIZE_W-1:0]  wr_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mss_pkg::out_item_t          out_item
);

    localparam int SW = mss_pkg::SIZE_W;
    localparam int RW = mss_pkg::ROW_W;

    logic               out_valid_reg;
    logic               out_valid_next;
    mss_pkg::out_item_t out_reg;
    mss_pkg::out_item_t out_next;

    logic [SW-1:0]      left_reg;
    logic [SW-1:0]      left_next;
    logic [SW-1:0]      diag_reg;
    logic [SW-1:0]      diag_next;
    logic [SW-1:0]      best_val_reg;
    logic [SW-1:0]      best_val_next;
    logic [RW-1:0]      best_row_reg;
    logic [RW-1:0]      best_row_next;
    logic [CW-1:0]      best_col_reg;
    logic [CW-1:0]      best_col_next;
    logic               err_reg;
    logic               err_next;

    logic [SW-1:0]      top;
    logic [SW-1:0]      left;
    logic [SW-1:0]      diag;
    logic [SW-1:0]      min_lt;
    logic [SW-1:0]      min_all;
    logic [SW-1:0]      size;
    logic [SW-1:0]      bv;
    logic [RW-1:0]      br;
    logic [CW-1:0]      bc;
    logic               err;
    logic               done;

    assign s1_fire = s1_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        top  = s1_ctl.row_zero ? '0 : (s1_ctl.fwd_hit ? out_reg.cell_size : rd_data);
        left = s1_ctl.col_zero ? '0 : left_reg;
        diag = (s1_ctl.col_zero || s1_ctl.row_zero) ? '0 : diag_reg;

        min_lt  = (left < top) ? left : top;
        min_all = (min_lt < diag) ? min_lt : diag;

        size = '0;
        if (s1_ctl.is_empty)
        begin
            size = (min_all == mss_pkg::SIZE_SAT) ? mss_pkg::SIZE_SAT : min_all + SW'(1);
        end

        // a new grid starts from a clean best square and error flag
        bv  = s1_ctl.start ? '0 : best_val_reg;
        br  = s1_ctl.start ? '0 : best_row_reg;
        bc  = s1_ctl.start ? '0 : best_col_reg;
        err = (s1_ctl.start ? 1'b0 : err_reg) | s1_ctl.is_bad;
        if (size > bv)
        begin
            bv = size;
            br = s1_row;
            bc = s1_col;
        end

        done = s1_ctl.last_col && s1_ctl.last_row;

        out_next.cell_size  = size;
        out_next.best_size  = bv;
        out_next.best_row   = br;
        out_next.best_col   = mss_pkg::BCOL_W'(bc);
        out_next.bad_symbol = err;
        out_next.grid_done  = done;
    end

    always_comb
    begin
        left_next     = left_reg;
        diag_next     = diag_reg;
        best_val_next = best_val_reg;
        best_row_next = best_row_reg;
        best_col_next = best_col_reg;
        err_next      = err_reg;
        if (s1_fire)
        begin
            if (done)
            begin
                left_next     = '0;
                diag_next     = '0;
                best_val_next = '0;
                best_row_next = '0;
                best_col_next = '0;
                err_next      = 1'b0;
            end
            else
            begin
                best_val_next = bv;
                best_row_next = br;
                best_col_next = bc;
                err_next      = err;
                if (s1_ctl.last_col)
                begin
                    left_next = '0;
                    diag_next = '0;
                end
                else
                begin
                    left_next = size;
                    diag_next = top;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_val_reg  <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_val_reg  <= best_val_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign wr_en     = s1_fire;
    assign wr_addr   = s1_col;
    assign wr_data   = size;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // the best square is never smaller than the cell just reported
    a_best_covers_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.cell_size <= out_reg.best_size)
        else $error("best size below cell size");

    // the last cell of a grid leaves a clean best square and error flag
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && done |=> best_val_reg == '0 && !err_reg && left_reg == '0)
        else $error("grid state not cleared after last cell");

    // an empty top-left corner always forms a square of one
    a_corner_unit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_ctl.col_zero && s1_ctl.row_zero && s1_ctl.is_empty
        |=> out_reg.cell_size == SW'(1))
        else $error("corner cell size not one");

    // an unknown symbol always shows in the error flag of its own item
    a_bad_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_ctl.is_bad |=> out_reg.bad_symbol && out_reg.cell_size == '0)
        else $error("unknown symbol not flagged");

endmodule

### bench/tb_max_square_scan.sv
// ----------------------------------------------------------------------------
// tb_max_square_scan
// Self-checking bench for the maximal square scanner.
// ----------------------------------------------------------------------------
// Cells are fed from a queue by a clocked driver. A predictor works out each
// cell's square size and the running best as the cell is accepted. A clocked
// monitor compares every result field by field with the oldest prediction.
// A short directed part covers the special cases. Random grids follow, over
// several register settings, with random idling on both sides and one long
// receiver hold-off.
module tb_max_square_scan;

    localparam int MAX_COLS    = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AFTER  = 400;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    mss_pkg::in_item_t             in_item;
    logic                          out_valid;
    logic                          out_stall;
    mss_pkg::out_item_t            out_item;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mss_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mss_pkg::CFG_DAT_W-1:0] cfg_data;

    max_square_scan #(
        .MAX_COLS(MAX_COLS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // register copies
    logic [mss_pkg::GCOLS_W-1:0] cfg_cols;
    logic [mss_pkg::ROW_W-1:0]   cfg_rows;
    logic [mss_pkg::SYM_W-1:0]   cfg_empty;
    logic [mss_pkg::SYM_W-1:0]   cfg_obst;

    // scan state of the predictor
    logic [mss_pkg::SIZE_W-1:0] above_sizes [MAX_COLS];
    logic [mss_pkg::SIZE_W-1:0] left_sz;
    logic [mss_pkg::SIZE_W-1:0] diag_sz;
    logic [mss_pkg::BCOL_W-1:0] col_pos;
    logic [mss_pkg::ROW_W-1:0]  row_pos;
    logic [mss_pkg::SIZE_W-1:0] best_sz;
    logic [mss_pkg::ROW_W-1:0]  best_r;
    logic [mss_pkg::BCOL_W-1:0] best_c;
    logic                       sym_error;

    mss_pkg::in_item_t  cell_feed[$];
    mss_pkg::out_item_t expected_cells[$];
    mss_pkg::out_item_t want;

    bit offer_live = 0;
    bit calm = 0;
    bit hold_used = 0;
    int hold_left = 0;
    int cells_taken = 0;
    int errors = 0;
    int cycles = 0;

    function automatic void clear_scan();
        left_sz   = '0;
        diag_sz   = '0;
        col_pos   = '0;
        row_pos   = '0;
        best_sz   = '0;
        best_r    = '0;
        best_c    = '0;
        sym_error = 1'b0;
    endfunction

    function automatic mss_pkg::out_item_t square_step(input mss_pkg::in_item_t c);
        int                 cols;
        int                 rows;
        int                 col;
        int                 top;
        int                 lft;
        int                 dia;
        int                 sz;
        logic               is_empty;
        logic               last_col;
        logic               last_row;
        mss_pkg::out_item_t r;
        cols = (cfg_cols == 0) ? 1 : int'(cfg_cols);
        if (cols > MAX_COLS)
            cols = MAX_COLS;
        rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
        if (c.grid_start)
            clear_scan();
        col = int'(col_pos);
        // obstacle code wins when both codes are equal
        if (c.symbol == cfg_obst)
            is_empty = 1'b0;
        else if (c.symbol == cfg_empty)
            is_empty = 1'b1;
        else
        begin
            is_empty  = 1'b0;
            sym_error = 1'b1;
        end
        top = (row_pos == 0) ? 0 : int'(above_sizes[col]);
        lft = (col == 0) ? 0 : int'(left_sz);
        dia = (col == 0 || row_pos == 0) ? 0 : int'(diag_sz);
        sz = 0;
        if (is_empty)
        begin
            sz = lft < top ? lft : top;
            sz = (sz < dia ? sz : dia) + 1;
            if (sz > int'(mss_pkg::SIZE_SAT))
                sz = int'(mss_pkg::SIZE_SAT);
        end
        above_sizes[col] = sz[mss_pkg::SIZE_W-1:0];
        if (sz > int'(best_sz))
        begin
            best_sz = sz[mss_pkg::SIZE_W-1:0];
            best_r  = row_pos;
            best_c  = col[mss_pkg::BCOL_W-1:0];
        end
        last_col = (col + 1 >= cols);
        last_row = (int'(row_pos) + 1 >= rows);
        r.cell_size  = sz[mss_pkg::SIZE_W-1:0];
        r.best_size  = best_sz;
        r.best_row   = best_r;
        r.best_col   = best_c;
        r.bad_symbol = sym_error;
        r.grid_done  = last_col && last_row;
        if (r.grid_done)
            clear_scan();
        else if (last_col)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            left_sz = '0;
            diag_sz = '0;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
            left_sz = sz[mss_pkg::SIZE_W-1:0];
            diag_sz = top[mss_pkg::SIZE_W-1:0];
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // driver: a new item is offered only once the previous one was taken
    always @(negedge clk)
    begin
        if (!offer_live)
        begin
            if (rst_n && cell_feed.size() != 0 && (calm || $urandom_range(99) >= 14))
            begin
                in_item    <= cell_feed[0];
                in_valid   <= 1'b1;
                offer_live = 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_cells.push_back(square_step(in_item));
            cell_feed.delete(0);
            offer_live = 0;
            cells_taken++;
        end
    end

    // receiver stall, with one long hold-off once enough cells went in
    always @(negedge clk)
    begin
        if (!hold_used && cells_taken >= HOLD_AFTER)
        begin
            hold_left = HOLD_CYCLES;
            hold_used = 1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 14);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %p", $time, out_item);
                errors++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("cell_size", 16'(want.cell_size), 16'(out_item.cell_size));
                check_field("best_size", 16'(want.best_size), 16'(out_item.best_size));
                check_field("best_row", want.best_row, out_item.best_row);
                check_field("best_col", 16'(want.best_col), 16'(out_item.best_col));
                check_field("bad_symbol", 16'(want.bad_symbol), 16'(out_item.bad_symbol));
                check_field("grid_done", 16'(want.grid_done), 16'(out_item.grid_done));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_cells.size());
            $display("tb_max_square_scan: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [mss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mss_pkg::CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            mss_pkg::REG_GRID_COLS:    cfg_cols  = val[mss_pkg::GCOLS_W-1:0];
            mss_pkg::REG_GRID_ROWS:    cfg_rows  = val[mss_pkg::ROW_W-1:0];
            mss_pkg::REG_EMPTY_SYM:    cfg_empty = val[mss_pkg::SYM_W-1:0];
            mss_pkg::REG_OBSTACLE_SYM: cfg_obst  = val[mss_pkg::SYM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cell(input logic [mss_pkg::SYM_W-1:0] sym, input logic start);
        mss_pkg::in_item_t c;
        c.symbol     = sym;
        c.grid_start = start;
        cell_feed.push_back(c);
    endtask

    // wait until every cell went through, plus the pipeline depth
    task automatic drain();
        while (cell_feed.size() != 0 || expected_cells.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] cols, input logic [15:0] rows,
                             input logic [7:0] emp, input logic [7:0] obs,
                             input int count, input bit noisy);
        int pick;
        write_reg(mss_pkg::REG_GRID_COLS, cols);
        write_reg(mss_pkg::REG_GRID_ROWS, rows);
        write_reg(mss_pkg::REG_EMPTY_SYM, 16'(emp));
        write_reg(mss_pkg::REG_OBSTACLE_SYM, 16'(obs));
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            // mostly empty cells so that squares grow, a few unknown codes; all random codes when noisy
            if (noisy || pick < 1)
                push_cell(8'($urandom_range(255)), (i == 0) || ($urandom_range(99) == 0));
            else if (pick < 16)
                push_cell(obs, (i == 0) || ($urandom_range(99) == 0));
            else
                push_cell(emp, (i == 0) || ($urandom_range(99) == 0));
        end
        drain();
    endtask

    initial
    begin
        logic [7:0] e_sym;
        logic [7:0] o_sym;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cfg_cols  = mss_pkg::GRID_COLS_RST;
        cfg_rows  = mss_pkg::GRID_ROWS_RST;
        cfg_empty = mss_pkg::EMPTY_SYM_RST;
        cfg_obst  = mss_pkg::OBSTACLE_SYM_RST;
        clear_scan();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-cell grids at reset values, unknown codes included
        push_cell(mss_pkg::EMPTY_SYM_RST, 1'b1);
        push_cell(mss_pkg::OBSTACLE_SYM_RST, 1'b0);
        push_cell(8'hFF, 1'b0);
        push_cell(8'h00, 1'b0);
        drain();

        // full 3x3 empty grid
        write_reg(mss_pkg::REG_GRID_COLS, 16'd3);
        write_reg(mss_pkg::REG_GRID_ROWS, 16'd3);
        push_cell(mss_pkg::EMPTY_SYM_RST, 1'b1);
        repeat (8) push_cell(mss_pkg::EMPTY_SYM_RST, 1'b0);
        drain();

        // size registers shrunk to zero in the middle of a grid
        push_cell(mss_pkg::EMPTY_SYM_RST, 1'b1);
        repeat (3) push_cell(mss_pkg::EMPTY_SYM_RST, 1'b0);
        drain();
        write_reg(mss_pkg::REG_GRID_COLS, 16'd0);
        write_reg(mss_pkg::REG_GRID_ROWS, 16'd0);
        push_cell(mss_pkg::EMPTY_SYM_RST, 1'b0);
        push_cell(mss_pkg::EMPTY_SYM_RST, 1'b0);
        drain();

        // equal codes count as obstacle
        write_reg(mss_pkg::REG_GRID_COLS, 16'd2);
        write_reg(mss_pkg::REG_GRID_ROWS, 16'd1);
        write_reg(mss_pkg::REG_EMPTY_SYM, 16'h00A5);
        write_reg(mss_pkg::REG_OBSTACLE_SYM, 16'h00A5);
        push_cell(8'hA5, 1'b1);
        push_cell(8'h00, 1'b0);
        drain();

        // random grids
        run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 40, 1'b0);
        run_phase(16'd1024, 16'd0, 8'h00, 8'hFF, 30, 1'b0);
        run_phase(16'd1, 16'd9, 8'($urandom_range(255)), 8'($urandom_range(255)), 60, 1'b0);
        calm = 1;
        run_phase(16'd12, 16'd10, mss_pkg::EMPTY_SYM_RST, mss_pkg::OBSTACLE_SYM_RST,
                  160, 1'b0);
        calm = 0;
        repeat (5)
        begin
            e_sym = 8'($urandom_range(255));
            o_sym = 8'($urandom_range(255));
            if ($urandom_range(7) == 0)
                o_sym = e_sym;
            run_phase(16'($urandom_range(1, 24)), 16'($urandom_range(1, 16)),
                      e_sym, o_sym, 100, 1'b0);
        end
        run_phase(16'd5, 16'd5, mss_pkg::EMPTY_SYM_RST, mss_pkg::OBSTACLE_SYM_RST,
                  40, 1'b1);

        drain();
        repeat (10) @(negedge clk);
        if (expected_cells.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, expected_cells.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_max_square_scan: done, clean");
        else
            $display("tb_max_square_scan: done, errors");
        $finish;
    end

endmodule

### max_square_scan.f
rtl/mss_pkg.sv
rtl/mss_row_mem.sv
rtl/mss_front.sv
rtl/mss_core.sv
rtl/max_square_scan.sv
bench/tb_max_square_scan.sv
